// ===== rtl/sd_pkg.sv =====
// Shared types and codes for the svndiff instruction decoder.
`timescale 1ns / 1ps

package sd_pkg;

  localparam int unsigned OUT_BITS = 64;

  typedef enum logic [1:0] {
    KIND_SRC = 2'd0,
    KIND_TGT = 2'd1,
    KIND_NEW = 2'd2,
    KIND_BAD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVF   = 2'd2,
    ST_KIND  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_HDR  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_OFF  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [OUT_BITS-1:0]  offset;
    logic [OUT_BITS-1:0]  length;
    status_e              status;
    logic                 section_end;
  } result_t;

endpackage

// ===== rtl/svndiff_instruction_decoder_top.sv =====
// Top level of the svndiff instruction decoder.
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_ready_o  | byte_req_i[7:0], last_byte_i
// out     | output    | out_valid_o / out_ready_i | kind_o, offset_o, length_o,
//         |           |                        | status_o, section_end_o
//
// One byte is taken per cycle, sustained, while the consumer does not stall.
// A byte is captured in the input register, is parsed by the decoder and its
// result (if any) is then loaded into the output register.
// Reset is asynchronous, active low, and returns the parser to the header
// phase with empty stages. A stalled consumer holds the result register; the
// input register still takes one more byte, then in_ready_o follows
// out_ready_i.

module svndiff_instruction_decoder_top #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_req_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [63:0] offset_o,
  output logic [63:0] length_o,
  output logic [1:0]  status_o,
  output logic        section_end_o
);

  sd_pkg::in_item_t in_item, stage_item;
  sd_pkg::result_t  step_res, out_res;
  logic             stage_valid;
  logic             out_space;
  logic             step;
  logic             emit;

  assign in_item.byte_req  = byte_req_i;
  assign in_item.last_byte = last_byte_i;

  // A byte is parsed whenever the result register can take what it yields.
  assign step = stage_valid && out_space;

  sd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  sd_decode #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_item),
    .emit_o   (emit),
    .result_o (step_res)
  );

  sd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .result_i    (step_res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign kind_o        = out_res.kind;
  assign offset_o      = out_res.offset;
  assign length_o      = out_res.length;
  assign status_o      = out_res.status;
  assign section_end_o = out_res.section_end;

endmodule

// ===== rtl/sd_in_stage.sv =====
// Input register stage for the instruction byte stream.
`timescale 1ns / 1ps

module sd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sd_pkg::in_item_t item_i,
  input  logic            take_i,
  output logic            valid_o,
  output sd_pkg::in_item_t item_o
);

  logic             valid_q, valid_d;
  sd_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/sd_decode.sv =====
// Instruction parser: phase, kind and varint accumulators, one byte per step.
`timescale 1ns / 1ps

module sd_decode #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  sd_pkg::in_item_t item_i,
  output logic             emit_o,
  output sd_pkg::result_t  result_o
);

  localparam int unsigned W = VALUE_BITS;

  sd_pkg::phase_e phase_q, phase_d;
  sd_pkg::kind_e  kind_q, kind_d;
  logic [W-1:0]   len_q, len_d;
  logic [W-1:0]   off_q, off_d;

  logic [7:0] b;
  logic       last;
  logic       len_ovf, off_ovf;
  logic [W-1:0] len_shift, off_shift;
  logic       len_done;

  assign b    = item_i.byte_req;
  assign last = item_i.last_byte;

  // A further varint byte overflows once any of the top seven bits is set.
  assign len_ovf   = |len_q[W-1:W-7];
  assign off_ovf   = |off_q[W-1:W-7];
  assign len_shift = {len_q[W-8:0], b[6:0]};
  assign off_shift = {off_q[W-8:0], b[6:0]};

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    len_d    = len_q;
    off_d    = off_q;
    emit_o   = 1'b0;
    len_done = 1'b0;
    result_o.kind        = kind_q;
    result_o.offset      = '0;
    result_o.length      = '0;
    result_o.status      = sd_pkg::ST_OK;
    result_o.section_end = last;

    case (phase_q)
      sd_pkg::PH_HDR: begin
        kind_d = sd_pkg::kind_e'(b[7:6]);
        len_d  = W'(b[5:0]);
        off_d  = '0;
        if (b[5:0] == 6'd0) begin
          phase_d = sd_pkg::PH_LEN;
          if (last) begin
            emit_o          = 1'b1;
            result_o.status = sd_pkg::ST_TRUNC;
          end
        end else begin
          len_done = 1'b1;
        end
      end
      sd_pkg::PH_LEN: begin
        if (len_ovf) begin
          emit_o          = 1'b1;
          result_o.status = sd_pkg::ST_OVF;
        end else begin
          len_d = len_shift;
          if (!b[7]) begin
            len_done = 1'b1;
          end else if (last) begin
            emit_o          = 1'b1;
            result_o.status = sd_pkg::ST_TRUNC;
          end
        end
      end
      sd_pkg::PH_OFF: begin
        if (off_ovf) begin
          emit_o          = 1'b1;
          result_o.status = sd_pkg::ST_OVF;
        end else begin
          off_d = off_shift;
          if (!b[7]) begin
            phase_d         = sd_pkg::PH_HDR;
            emit_o          = 1'b1;
            result_o.offset = sd_pkg::OUT_BITS'(off_shift);
            result_o.length = sd_pkg::OUT_BITS'(len_q);
          end else if (last) begin
            emit_o          = 1'b1;
            result_o.status = sd_pkg::ST_TRUNC;
          end
        end
      end
      sd_pkg::PH_DROP: begin
        if (last) begin
          phase_d = sd_pkg::PH_HDR;
        end
      end
      default: begin
        phase_d = sd_pkg::PH_HDR;
      end
    endcase

    // Length complete: copies go on to the offset, new data finishes here, kind three is a kind error.
    if (len_done) begin
      result_o.kind = kind_d;
      case (kind_d)
        sd_pkg::KIND_SRC, sd_pkg::KIND_TGT: begin
          off_d   = '0;
          phase_d = sd_pkg::PH_OFF;
          if (last) begin
            emit_o          = 1'b1;
            result_o.status = sd_pkg::ST_TRUNC;
          end
        end
        sd_pkg::KIND_NEW: begin
          phase_d         = sd_pkg::PH_HDR;
          emit_o          = 1'b1;
          result_o.length = sd_pkg::OUT_BITS'(len_d);
        end
        default: begin
          emit_o          = 1'b1;
          result_o.status = sd_pkg::ST_KIND;
        end
      endcase
    end else if (phase_q == sd_pkg::PH_HDR) begin
      result_o.kind = kind_d;
    end

    // Any error result drops the rest of the section.
    if (emit_o && (result_o.status != sd_pkg::ST_OK)) begin
      phase_d = last ? sd_pkg::PH_HDR : sd_pkg::PH_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sd_pkg::PH_HDR;
      kind_q  <= sd_pkg::KIND_SRC;
      len_q   <= '0;
      off_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      off_q   <= off_d;
    end
  end

endmodule

// ===== rtl/sd_out_stage.sv =====
// Result register towards the consumer.
`timescale 1ns / 1ps

module sd_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sd_pkg::result_t result_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sd_pkg::result_t result_o
);

  logic            valid_q, valid_d;
  sd_pkg::result_t result_q;

  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/sd_checker.sv =====
// Port-level checks for the svndiff instruction decoder, bound to the top.
`timescale 1ns / 1ps

module sd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  byte_req_i,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [63:0] offset_o,
  input logic [63:0] length_o,
  input logic [1:0]  status_o,
  input logic        section_end_o
);

  // A waiting result is held until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(offset_o) && $stable(length_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Error results carry no offset or length.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != sd_pkg::ST_OK) |-> offset_o == '0 && length_o == '0)
    else $error("error result with non-zero fields");

  // Only kind three raises the kind error, and kind three never completes.
  // Kind three may still end in truncation or overflow while its length is read.
  a_kind_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o != sd_pkg::ST_KIND) || (kind_o == sd_pkg::KIND_BAD)) &&
      ((kind_o != sd_pkg::KIND_BAD) || (status_o != sd_pkg::ST_OK)))
    else $error("kind error mismatch");

  // New data has no offset.
  a_new_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == sd_pkg::KIND_NEW) |-> offset_o == '0)
    else $error("new data with offset");

endmodule

bind svndiff_instruction_decoder_top sd_checker u_sd_checker (.*);
